// File: sv/xrg_pkg.sv
// ---------------------------------------------------------------------------
// xrg_pkg: shared types, constants and functions for the xorshift128 range
// generator (opcodes, register indexes, controller states, state update).
// ---------------------------------------------------------------------------
package xrg_pkg;

    localparam int WORD_W = 32;
    localparam int CNT_W  = $clog2(WORD_W);
    localparam int IDX_W  = 2;

    localparam logic [WORD_W-1:0] RST_WORD_A = 32'd123456789;
    localparam logic [WORD_W-1:0] RST_WORD_B = 32'd362436069;
    localparam logic [WORD_W-1:0] RST_WORD_C = 32'd521288629;
    localparam logic [WORD_W-1:0] RST_WORD_D = 32'd88675123;

    typedef enum logic [1:0] {
        OP_RAW    = 2'd0,
        OP_RANGED = 2'd1,
        OP_RESEED = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    typedef enum logic [IDX_W-1:0] {
        REG_WORD_A = 2'd0,
        REG_WORD_B = 2'd1,
        REG_WORD_C = 2'd2,
        REG_WORD_D = 2'd3
    } reg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // word accepted: latch operands, update state
        logic div_step;  // one restoring-division step
        logic out_load;  // move result into output register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic need_div;  // incoming word is a ranged draw with nonzero span
        logic div_last;  // current step is the final one
        logic out_free;  // output register can take a new word
    } status_t;

    typedef logic [WORD_W-1:0] word_t;

    // new fourth word of xorshift128
    function automatic word_t xs_next(input word_t a, input word_t d);
        word_t t;
        t = a ^ (a << 11);
        return (d ^ (d >> 19)) ^ (t ^ (t >> 8));
    endfunction

    // even nibbles packed into a 16-bit halfword
    function automatic logic [15:0] nib_even(input word_t s);
        return {s[27:24], s[19:16], s[11:8], s[3:0]};
    endfunction

    // odd nibbles packed into a 16-bit halfword
    function automatic logic [15:0] nib_odd(input word_t s);
        return {s[31:28], s[23:20], s[15:12], s[7:4]};
    endfunction

endpackage

// File: sv/xrg_ctrl.sv
// ---------------------------------------------------------------------------
// xrg_ctrl: request sequencer
// Accepts a word, runs the divider for ranged draws, hands the result to the
// output register.
// ---------------------------------------------------------------------------
module xrg_ctrl
    import xrg_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    output logic    s_tready,
    input  status_t status,
    output cmd_t    cmd,
    output state_t  state
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = status.need_div ? ST_DIVIDE : ST_FINISH;
                end
            end
            ST_DIVIDE: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign state = state_reg;

endmodule

// File: sv/xrg_dp.sv
// ---------------------------------------------------------------------------
// xrg_dp: generator datapath
// State words, default registers, radix-2 remainder unit and output register.
// ---------------------------------------------------------------------------
module xrg_dp
    import xrg_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [95:0]         s_tdata,
    input  logic [1:0]          s_tuser,
    input  logic                cfg_we,
    input  logic [IDX_W-1:0]    cfg_index,
    input  logic [WORD_W-1:0]   cfg_data,
    input  cmd_t                cmd,
    output status_t             status,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [WORD_W-1:0]   m_tdata
);

    opcode_t in_op;
    word_t   in_seed, in_low, in_high, in_span;

    word_t dflt_a_reg, dflt_b_reg, dflt_c_reg, dflt_d_reg;
    word_t word_a_reg, word_b_reg, word_c_reg, word_d_reg;
    word_t word_a_next, word_b_next, word_c_next, word_d_next;
    word_t draw;

    opcode_t            op_reg;
    logic               span_zero_reg;
    word_t              low_reg, span_reg;
    word_t              dvd_reg, dvd_next;
    word_t              rem_reg, rem_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [WORD_W:0]    trial;
    word_t              result;
    logic               out_valid_reg;
    word_t              out_data_reg;

    assign in_op   = opcode_t'(s_tuser);
    assign in_seed = s_tdata[31:0];
    assign in_low  = s_tdata[63:32];
    assign in_high = s_tdata[95:64];
    assign in_span = in_high - in_low + 32'd1;

    assign draw = xs_next(word_a_reg, word_d_reg);

    assign status.need_div = (in_op == OP_RANGED) && (in_span != '0);
    assign status.div_last = (cnt_reg == {CNT_W{1'b1}});
    assign status.out_free = !out_valid_reg || m_tready;

    // default word registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dflt_a_reg <= RST_WORD_A;
            dflt_b_reg <= RST_WORD_B;
            dflt_c_reg <= RST_WORD_C;
            dflt_d_reg <= RST_WORD_D;
        end else if (cfg_we) begin
            unique case (reg_index_t'(cfg_index))
                REG_WORD_A: dflt_a_reg <= cfg_data;
                REG_WORD_B: dflt_b_reg <= cfg_data;
                REG_WORD_C: dflt_c_reg <= cfg_data;
                REG_WORD_D: dflt_d_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // generator state update
    always_comb begin
        word_a_next = word_a_reg;
        word_b_next = word_b_reg;
        word_c_next = word_c_reg;
        word_d_next = word_d_reg;
        if (cmd.load) begin
            case (in_op) inside
                OP_RAW, OP_RANGED: begin
                    word_a_next = word_b_reg;
                    word_b_next = word_c_reg;
                    word_c_next = word_d_reg;
                    word_d_next = draw;
                end
                OP_RESEED: begin
                    if (in_seed == '0) begin
                        word_a_next = dflt_a_reg;
                        word_b_next = dflt_b_reg;
                        word_c_next = dflt_c_reg;
                        word_d_next = dflt_d_reg;
                    end else begin
                        word_a_next = in_seed;
                        word_b_next = {in_seed[15:0], in_seed[31:16]};
                        word_c_next = {nib_odd(in_seed), nib_even(in_seed)};
                        word_d_next = {nib_even(in_seed), nib_odd(in_seed)};
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_a_reg <= RST_WORD_A;
            word_b_reg <= RST_WORD_B;
            word_c_reg <= RST_WORD_C;
            word_d_reg <= RST_WORD_D;
        end else begin
            word_a_reg <= word_a_next;
            word_b_reg <= word_b_next;
            word_c_reg <= word_c_next;
            word_d_reg <= word_d_next;
        end
    end

    // restoring remainder, one dividend bit per step
    assign trial = {rem_reg, dvd_reg[WORD_W-1]};

    always_comb begin
        dvd_next = dvd_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        if (cmd.load) begin
            dvd_next = draw;
            rem_next = '0;
            cnt_next = '0;
        end else if (cmd.div_step) begin
            dvd_next = {dvd_reg[WORD_W-2:0], 1'b0};
            rem_next = (trial >= {1'b0, span_reg}) ? WORD_W'(trial - {1'b0, span_reg})
                                                   : trial[WORD_W-1:0];
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
        if (cmd.load) begin
            op_reg        <= in_op;
            low_reg       <= in_low;
            span_reg      <= in_span;
            span_zero_reg <= (in_span == '0);
        end
    end

    // full-range draws skip the divider; dvd_reg still holds the draw then
    always_comb begin
        case (op_reg)
            OP_RAW:    result = dvd_reg;
            OP_RANGED: result = (span_zero_reg ? dvd_reg : rem_reg) + low_reg;
            default:   result = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// File: sv/xorshift128_range_generator.sv
// ---------------------------------------------------------------------------
// xorshift128_range_generator: xorshift128 generator with ranged draws
// Each input word carries an opcode in s_tuser: raw draw, ranged draw or
// reseed. A raw draw or a reseed goes from acceptance through the finish
// state into the output register; a ranged draw first runs the radix-2
// remainder unit, which retires one dividend bit per cycle (a full-range
// draw skips it). A result held back by m_tready while the output
// register is still full keeps the block waiting in the finish state.
// One request is in flight at a time; the next word is accepted while the
// previous result still waits in the output register. Reseed and unused
// opcodes return zero. Default words are written through the cfg port and
// take effect at the next zero seed.
// ---------------------------------------------------------------------------
module xorshift128_range_generator
    import xrg_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [95:0]         s_tdata,    // seed_value, range_low, range_high
    input  logic [1:0]          s_tuser,    // opcode
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [WORD_W-1:0]   m_tdata,    // random_value
    input  logic                cfg_we,
    input  logic [IDX_W-1:0]    cfg_index,
    input  logic [WORD_W-1:0]   cfg_data
);

    cmd_t    cmd;
    status_t status;
    state_t  state;

    xrg_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd),
        .state    (state)
    );

    xrg_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // one request at a time: no word taken right after an accept
    a_single_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("word accepted while a request is in flight");

    // a result load always shows up on the output
    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_tvalid)
        else $error("result load did not raise m_tvalid");

    // output register only loaded from the finish state
    a_load_state: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (state == ST_FINISH))
        else $error("result loaded outside finish state");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> (!m_tvalid && s_tready))
        else $error("bad state after reset");

endmodule
